// ----- design/ipfr_pkg.sv -----
// Shared types and constants for the IR pulse-distance frame receiver.
// Used by every module of the block except ipfr_ram; depends on nothing else.
package ipfr_pkg;

   localparam int FRAME_BITS_DEFAULT = 64;
   localparam int FIFO_DEPTH_DEFAULT = 8;
   localparam int GROUP_BITS         = 32;
   localparam int CSR_ADDR_W         = 5;
   localparam int CSR_DATA_W         = 32;

   // Register reset values
   localparam logic        DECODE_MODE_RST    = 1'b0;
   localparam logic        RECEIVE_ENABLE_RST = 1'b1;
   localparam logic [15:0] LEADER_MIN_RST     = 16'd9000;
   localparam logic [15:0] LONG_MIN_RST       = 16'd2000;
   localparam logic [15:0] LONG_MAX_RST       = 16'd2500;
   localparam logic [15:0] SHORT_MIN_RST      = 16'd800;
   localparam logic [15:0] SHORT_MAX_RST      = 16'd1500;

   typedef enum logic [2:0] {
      REG_DECODE_MODE    = 3'd0,
      REG_RECEIVE_ENABLE = 3'd1,
      REG_LEADER_MIN     = 3'd2,
      REG_LONG_MIN       = 3'd3,
      REG_LONG_MAX       = 3'd4,
      REG_SHORT_MIN      = 3'd5,
      REG_SHORT_MAX      = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_BUSY  = 4'd0,
      ST_ENQ   = 4'd1,
      ST_DUP   = 4'd2,
      ST_FULL  = 4'd3,
      ST_NOGRP = 4'd4,
      ST_ABORT = 4'd5,
      ST_ZERO  = 4'd6,
      ST_POP   = 4'd7,
      ST_EMPTY = 4'd8,
      ST_DIS   = 4'd9
   } status_type;

   typedef enum logic {
      OP_CAPTURE = 1'b0,
      OP_POP     = 1'b1
   } operation_type;

   typedef struct packed {
      logic        decode_mode;
      logic        receive_enable;
      logic [15:0] leader_min;
      logic [15:0] long_min;
      logic [15:0] long_max;
      logic [15:0] short_min;
      logic [15:0] short_max;
   } cfg_type;

   typedef struct packed {
      logic        found;
      logic        zero_sum;
      logic [31:0] frame;
   } group_result_type;

   typedef struct packed {
      logic        pop;
      logic        offer;
      logic        enable;
      logic [31:0] frame;
   } queue_req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] data;
   } queue_rsp_type;

endpackage

// ----- design/ir_pulse_frame_receiver_unit.sv -----
// Top level of the IR pulse-distance frame receiver: stream ports, register file,
// input and result registers. Depends on ipfr_pkg, ipfr_capture, ipfr_group_check, ipfr_frame_queue.
//
//   Channel   Direction   Handshake                  Payload
//   req_*     in          tvalid/tready              tdata timestamp, tlast last_capture, tuser operation
//   rsp_*     out         tvalid/tready              tdata frame_data, tuser status
//   csr_*     in/out      psel/penable/pready (APB)  seven registers at byte addresses 4*i
//
// Each transaction on req_ produces exactly one transaction on rsp_; it passes through the input
// register and then the result register. One transaction is accepted per cycle unless rsp_ is
// stalled: the work is done in a single pass between the input register and the result register.
// A stall on rsp_ holds the result register; one more transaction may still wait in the
// input register, after which req_tready drops.
// Reset is synchronous and active high. It restores the register defaults and empties the
// frame queue; the queue storage itself is not cleared, and never-written slots are never read.
module ir_pulse_frame_receiver_unit #(
   parameter int FRAME_BITS = ipfr_pkg::FRAME_BITS_DEFAULT,
   parameter int FIFO_DEPTH = ipfr_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // [15:0] timestamp
   input  logic                                req_tlast,  // last_capture
   input  logic                                req_tuser,  // [0] operation
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [31:0] frame_data
   output logic [3:0]                          rsp_tuser,  // [3:0] status
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ipfr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ipfr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ipfr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import ipfr_pkg::*;

   // ---------------------------------------------------------------------------------
   // Register file. Writes complete in the access phase; pready is tied high.
   // ---------------------------------------------------------------------------------
   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DECODE_MODE:    cfg_in.decode_mode    = csr_pwdata[0];
            REG_RECEIVE_ENABLE: cfg_in.receive_enable = csr_pwdata[0];
            REG_LEADER_MIN:     cfg_in.leader_min     = csr_pwdata[15:0];
            REG_LONG_MIN:       cfg_in.long_min       = csr_pwdata[15:0];
            REG_LONG_MAX:       cfg_in.long_max       = csr_pwdata[15:0];
            REG_SHORT_MIN:      cfg_in.short_min      = csr_pwdata[15:0];
            REG_SHORT_MAX:      cfg_in.short_max      = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DECODE_MODE:    csr_prdata = CSR_DATA_W'(cfg_ff.decode_mode);
         REG_RECEIVE_ENABLE: csr_prdata = CSR_DATA_W'(cfg_ff.receive_enable);
         REG_LEADER_MIN:     csr_prdata = CSR_DATA_W'(cfg_ff.leader_min);
         REG_LONG_MIN:       csr_prdata = CSR_DATA_W'(cfg_ff.long_min);
         REG_LONG_MAX:       csr_prdata = CSR_DATA_W'(cfg_ff.long_max);
         REG_SHORT_MIN:      csr_prdata = CSR_DATA_W'(cfg_ff.short_min);
         REG_SHORT_MAX:      csr_prdata = CSR_DATA_W'(cfg_ff.short_max);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_mode    <= DECODE_MODE_RST;
         cfg_ff.receive_enable <= RECEIVE_ENABLE_RST;
         cfg_ff.leader_min     <= LEADER_MIN_RST;
         cfg_ff.long_min       <= LONG_MIN_RST;
         cfg_ff.long_max       <= LONG_MAX_RST;
         cfg_ff.short_min      <= SHORT_MIN_RST;
         cfg_ff.short_max      <= SHORT_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Input register. It refills in the same cycle its contents move on, so a new
   // transaction is taken every cycle unless the result register is stalled.
   // ---------------------------------------------------------------------------------
   logic          in_valid_ff, in_valid_in;
   operation_type in_op_ff,    in_op_in;
   logic [15:0]   in_ts_ff,    in_ts_in;
   logic          in_last_ff,  in_last_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff,    status_in;
   logic [31:0] data_ff,      data_in;

   logic advance;
   logic process;
   logic req_fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_ts_in    = in_ts_ff;
      in_last_in  = in_last_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_op_in    = operation_type'(req_tuser);
         in_ts_in    = req_tdata;
         in_last_in  = req_tlast;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_op_ff   <= in_op_in;
      in_ts_ff   <= in_ts_in;
      in_last_ff <= in_last_in;
   end

   // ---------------------------------------------------------------------------------
   // Single-pass work: interval and bit update, then, on a buffer's final capture,
   // the group check on the freshly updated bits and the offer to the frame queue.
   // ---------------------------------------------------------------------------------
   logic                  cap_step;
   logic [FRAME_BITS-1:0] store_next;
   logic                  aborted_next;
   group_result_type      group;
   queue_req_type         queue_req;
   queue_rsp_type         queue_rsp;
   logic                  evaluate;

   assign cap_step = process && (in_op_ff == OP_CAPTURE);
   assign evaluate = cap_step && in_last_ff;

   ipfr_capture #(
      .FRAME_BITS (FRAME_BITS)
   ) u_capture (
      .clock        (clock),
      .reset        (reset),
      .step         (cap_step),
      .last         (in_last_ff),
      .timestamp    (in_ts_ff),
      .cfg          (cfg_ff),
      .store_next   (store_next),
      .aborted_next (aborted_next)
   );

   ipfr_group_check #(
      .FRAME_BITS (FRAME_BITS)
   ) u_group_check (
      .store  (store_next),
      .result (group)
   );

   always_comb begin
      queue_req.pop    = process && (in_op_ff == OP_POP);
      queue_req.offer  = evaluate && !aborted_next && cfg_ff.receive_enable
                         && group.found && !group.zero_sum;
      queue_req.enable = cfg_ff.receive_enable;
      queue_req.frame  = group.frame;
   end

   ipfr_frame_queue #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_frame_queue (
      .clock (clock),
      .reset (reset),
      .req   (queue_req),
      .rsp   (queue_rsp)
   );

   // ---------------------------------------------------------------------------------
   // Result register. Abort outranks a disabled receiver; a capture that does not
   // close a buffer reports busy with zero data.
   // ---------------------------------------------------------------------------------
   always_comb begin
      status_in = ST_BUSY;
      data_in   = '0;
      if (in_op_ff == OP_POP) begin
         status_in = queue_rsp.status;
         data_in   = queue_rsp.data;
      end else if (in_last_ff) begin
         if (aborted_next) begin
            status_in = ST_ABORT;
         end else if (!cfg_ff.receive_enable) begin
            status_in = ST_DIS;
         end else if (!group.found) begin
            status_in = ST_NOGRP;
         end else if (group.zero_sum) begin
            status_in = ST_ZERO;
         end else begin
            status_in = queue_rsp.status;
            data_in   = queue_rsp.data;
         end
      end
      if (!process) begin
         status_in = status_ff;
         data_in   = data_ff;
      end
      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = status_ff;

endmodule

// ----- design/ipfr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module ipfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ipfr_capture.sv -----
// Interval former and bit collector: keeps the per-buffer capture state.
// Depends on ipfr_pkg for the configuration struct.
module ipfr_capture #(
   parameter int FRAME_BITS = ipfr_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    last,
   input  logic [15:0]             timestamp,
   input  ipfr_pkg::cfg_type       cfg,
   output logic [FRAME_BITS-1:0]   store_next,
   output logic                    aborted_next
);
   import ipfr_pkg::*;

   localparam int BC_W  = $clog2(FRAME_BITS + 1);
   localparam int IDX_W = $clog2(FRAME_BITS);

   logic [15:0]           prev_ff,    prev_in;
   logic                  have_ff,    have_in;
   logic                  leader_ff,  leader_in;
   logic                  started_ff, started_in;
   logic                  aborted_ff, aborted_in;
   logic [BC_W-1:0]       count_ff,   count_in;
   logic [FRAME_BITS-1:0] store_ff,   store_in;

   logic [15:0] interval;
   logic        is_long;
   logic        is_short;
   logic        starter;

   assign interval = timestamp - prev_ff;
   assign is_long  = (interval > cfg.long_min) && (interval < cfg.long_max);
   assign is_short = (interval > cfg.short_min) && (interval < cfg.short_max);
   // Long wins when both windows match, so short only starts a frame when not long.
   assign starter  = cfg.decode_mode ? (is_short && !is_long) : is_long;

   always_comb begin
      prev_in    = prev_ff;
      have_in    = have_ff;
      leader_in  = leader_ff;
      started_in = started_ff;
      aborted_in = aborted_ff;
      count_in   = count_ff;
      store_in   = store_ff;
      if (step && !aborted_ff) begin
         if (have_ff) begin
            if (interval > cfg.leader_min) begin
               leader_in = 1'b1;
            end
            if (leader_in && (is_long || is_short)) begin
               if (started_ff) begin
                  if (count_ff < BC_W'(FRAME_BITS)) begin
                     if (is_long) begin
                        store_in = store_ff | (FRAME_BITS'(1) << count_ff[IDX_W-1:0]);
                     end
                     count_in = count_ff + BC_W'(1);
                  end
               end else if (starter) begin
                  started_in = 1'b1;
               end else begin
                  aborted_in = 1'b1;
               end
            end
         end
         prev_in = timestamp;
         have_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         have_ff    <= 1'b0;
         leader_ff  <= 1'b0;
         started_ff <= 1'b0;
         aborted_ff <= 1'b0;
         count_ff   <= '0;
         store_ff   <= '0;
      end else if (step && last) begin
         prev_ff    <= prev_in;
         have_ff    <= 1'b0;
         leader_ff  <= 1'b0;
         started_ff <= 1'b0;
         aborted_ff <= 1'b0;
         count_ff   <= '0;
         store_ff   <= '0;
      end else begin
         prev_ff    <= prev_in;
         have_ff    <= have_in;
         leader_ff  <= leader_in;
         started_ff <= started_in;
         aborted_ff <= aborted_in;
         count_ff   <= count_in;
         store_ff   <= store_in;
      end
   end

   assign store_next   = store_in;
   assign aborted_next = aborted_in;

endmodule

// ----- design/ipfr_group_check.sv -----
// Checksum test over the 32-bit groups of the collected bits; picks the first valid one.
// Depends on ipfr_pkg for the group result struct.
module ipfr_group_check #(
   parameter int FRAME_BITS = ipfr_pkg::FRAME_BITS_DEFAULT
) (
   input  logic [FRAME_BITS-1:0]      store,
   output ipfr_pkg::group_result_type result
);
   import ipfr_pkg::*;

   localparam int NUM_GROUPS = FRAME_BITS / GROUP_BITS;

   always_comb begin
      logic [31:0] word;
      logic [9:0]  sum;
      logic [11:0] square;
      logic [5:0]  check;
      result = '0;
      // Walk from the top group down so the lowest valid group is the one kept.
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         word   = store[g*GROUP_BITS +: GROUP_BITS];
         sum    = 10'(word[7:0]) + 10'(word[15:8]) + 10'(word[23:16]);
         square = sum[5:0] * sum[5:0];
         check  = ~square[5:0];
         if (check == word[29:24]) begin
            result.found    = 1'b1;
            result.zero_sum = (sum == '0);
            result.frame    = {1'b0, word[30:0]};
         end
      end
   end

endmodule

// ----- design/ipfr_frame_queue.sv -----
// Frame queue: duplicate filter against the last accepted frame, FIFO pointers and storage.
// Depends on ipfr_pkg and instantiates ipfr_ram.
module ipfr_frame_queue #(
   parameter int FIFO_DEPTH = ipfr_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ipfr_pkg::queue_req_type req,
   output ipfr_pkg::queue_rsp_type rsp
);
   import ipfr_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [PTR_W-1:0] head_ff,        head_in;
   logic [PTR_W-1:0] tail_ff,        tail_in;
   logic [CNT_W-1:0] count_ff,       count_in;
   logic [31:0]      last_frame_ff,  last_frame_in;
   logic             last_valid_ff,  last_valid_in;
   logic             bypass_ff,      bypass_in;
   logic [31:0]      bypass_data_ff, bypass_data_in;

   logic        wr_en;
   logic [31:0] ram_rdata;
   logic [31:0] head_data;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   // The RAM always reads the slot that will be at the head; a write into that
   // same slot in the same cycle is caught by the bypass register.
   assign head_data = bypass_ff ? bypass_data_ff : ram_rdata;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      last_frame_in = last_frame_ff;
      last_valid_in = last_valid_ff;
      wr_en         = 1'b0;
      rsp.status    = ST_BUSY;
      rsp.data      = '0;
      if (req.offer) begin
         rsp.data = req.frame;
         if (last_valid_ff && (req.frame == last_frame_ff)) begin
            rsp.status = ST_DUP;
         end else begin
            if (count_ff < CNT_W'(FIFO_DEPTH)) begin
               wr_en      = 1'b1;
               tail_in    = next_slot(tail_ff);
               count_in   = count_ff + CNT_W'(1);
               rsp.status = ST_ENQ;
            end else begin
               rsp.status = ST_FULL;
            end
            last_frame_in = req.frame;
            last_valid_in = 1'b1;
         end
      end else if (req.pop) begin
         if (!req.enable) begin
            rsp.status = ST_DIS;
         end else if (count_ff == '0) begin
            rsp.status = ST_EMPTY;
         end else begin
            rsp.status = ST_POP;
            rsp.data   = head_data;
            head_in    = next_slot(head_ff);
            count_in   = count_ff - CNT_W'(1);
         end
      end
      bypass_in      = wr_en && (tail_ff == head_in);
      bypass_data_in = req.frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         last_frame_ff <= '0;
         last_valid_ff <= 1'b0;
         bypass_ff     <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         last_frame_ff <= last_frame_in;
         last_valid_ff <= last_valid_in;
         bypass_ff     <= bypass_in;
      end
      bypass_data_ff <= bypass_data_in;
   end

   ipfr_ram #(
      .WIDTH (32),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req.frame),
      .rd_addr (head_in),
      .rd_data (ram_rdata)
   );

endmodule
